/* design/wwbf_pkg.sv */
package wwbf_pkg;

    localparam int CP_BITS         = 21;
    localparam int BYTES_BITS      = 3;
    localparam int ADV_BITS        = 16;
    localparam int LIMIT_BITS      = 24;
    localparam int DEF_OFFSET_BITS = 16;
    localparam int DEF_WIDTH_BITS  = 24;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = {LIMIT_BITS{1'b1}};

    localparam logic [CP_BITS-1:0] CH_TAB       = 21'h000009;
    localparam logic [CP_BITS-1:0] CH_NL        = 21'h00000A;
    localparam logic [CP_BITS-1:0] CH_CR        = 21'h00000D;
    localparam logic [CP_BITS-1:0] CH_SPACE     = 21'h000020;
    localparam logic [CP_BITS-1:0] CH_BANG      = 21'h000021;
    localparam logic [CP_BITS-1:0] CH_COMMA     = 21'h00002C;
    localparam logic [CP_BITS-1:0] CH_HYPHEN    = 21'h00002D;
    localparam logic [CP_BITS-1:0] CH_DOT       = 21'h00002E;
    localparam logic [CP_BITS-1:0] CH_ZERO      = 21'h000030;
    localparam logic [CP_BITS-1:0] CH_NINE      = 21'h000039;
    localparam logic [CP_BITS-1:0] CH_COLON     = 21'h00003A;
    localparam logic [CP_BITS-1:0] CH_SEMI      = 21'h00003B;
    localparam logic [CP_BITS-1:0] CH_QUESTION  = 21'h00003F;
    localparam logic [CP_BITS-1:0] CH_ZW_SPACE  = 21'h00200B;
    localparam logic [CP_BITS-1:0] CH_IDEO_SPACE = 21'h003000;

    function automatic logic is_digit(input logic [CP_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [CP_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_IDEO_SPACE) || (c == CH_ZW_SPACE);
    endfunction

    function automatic logic is_excl(input logic [CP_BITS-1:0] c);
        return (c == CH_BANG) || (c == CH_QUESTION);
    endfunction

    // Line break opportunity after c, given the following code point.
    function automatic logic break_after(
        input logic [CP_BITS-1:0] c,
        input logic [CP_BITS-1:0] nc,
        input logic               after_digit
    );
        logic brk;
        brk = 1'b0;
        if (is_blank(c)) begin
            brk = !(is_excl(nc) || (nc == CH_COLON) || (nc == CH_SEMI));
        end else if ((c == CH_COMMA) || (c == CH_SEMI) || (c == CH_HYPHEN)) begin
            brk = 1'b1;
        end else if (c == CH_DOT) begin
            // hold decimal numbers and ellipses together
            brk = !(after_digit && is_digit(nc)) && (nc != CH_DOT);
        end else if (is_excl(c)) begin
            brk = !is_excl(nc);
        end
        return brk;
    endfunction

endpackage

/* design/word_wrap_break_finder.sv */
// Greedy word-wrap break finder.
//
// Input channel (s_valid/s_ready): one decoded character per request, with
// its code point, UTF-8 byte count, glyph advance and the following code
// point. s_first_char opens a new text, s_last_char closes it.
// Result channel (m_valid/m_ready): at most one result per text, giving the
// byte offset where the next line begins, with m_forced when no break point
// existed and m_reached_end when the whole text fits.
// Config channel (cfg_valid/cfg_ready): writes wrap_limit; always ready.
// wrap_limit is to be written only while the block is idle; the block does not enforce this.
//
// Throughput is one character per cycle unless the result channel stalls.
// A request is captured in an input register and checked there against the
// line state, and its result is written into the output register.
// When the receiver stalls, the result holds in the output register and one
// more request waits in the input register before s_ready drops.
// Reset clears the line state, empties both registers and sets wrap_limit
// to its maximum.
module word_wrap_break_finder #(
    parameter int OFFSET_BITS = wwbf_pkg::DEF_OFFSET_BITS,
    parameter int WIDTH_BITS  = wwbf_pkg::DEF_WIDTH_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wwbf_pkg::LIMIT_BITS-1:0]   cfg_wrap_limit,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_first_char,
    input  logic [wwbf_pkg::CP_BITS-1:0]      s_code_point,
    input  logic [wwbf_pkg::BYTES_BITS-1:0]   s_char_bytes,
    input  logic [wwbf_pkg::ADV_BITS-1:0]     s_glyph_advance,
    input  logic [wwbf_pkg::CP_BITS-1:0]      s_next_code,
    input  logic                              s_last_char,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [OFFSET_BITS-1:0]            m_break_offset,
    output logic                              m_forced,
    output logic                              m_reached_end
);
    import wwbf_pkg::*;

    localparam int CMP_BITS = (WIDTH_BITS > LIMIT_BITS) ? WIDTH_BITS : LIMIT_BITS;

    // configuration
    logic [LIMIT_BITS-1:0]  wrap_limit_reg;

    // input register
    logic                   in_valid_reg;
    logic                   in_first_reg;
    logic [CP_BITS-1:0]     in_code_reg;
    logic [BYTES_BITS-1:0]  in_bytes_reg;
    logic [ADV_BITS-1:0]    in_adv_reg;
    logic [CP_BITS-1:0]     in_next_reg;
    logic                   in_last_reg;

    // line state
    logic [WIDTH_BITS-1:0]  line_width_reg, line_width_next;
    logic [WIDTH_BITS-1:0]  word_width_reg, word_width_next;
    logic                   break_valid_reg, break_valid_next;
    logic [OFFSET_BITS-1:0] break_pos_reg, break_pos_next;
    logic [OFFSET_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic                   after_digit_reg, after_digit_next;
    logic                   finished_reg, finished_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [OFFSET_BITS-1:0] out_offset_reg, out_offset_next;
    logic                   out_forced_reg, out_forced_next;
    logic                   out_end_reg, out_end_next;

    logic                   out_free;
    logic                   fire;
    logic                   emit;

    // state as seen by this character, after an optional text restart
    logic [WIDTH_BITS-1:0]  cur_line;
    logic [WIDTH_BITS-1:0]  cur_word;
    logic                   cur_bvalid;
    logic [OFFSET_BITS-1:0] cur_bpos;
    logic [OFFSET_BITS-1:0] cur_byte;
    logic                   cur_after_digit;
    logic                   cur_finished;

    logic [BYTES_BITS-1:0]  nbytes;
    logic [OFFSET_BITS-1:0] next_pos;
    logic [WIDTH_BITS:0]    word_sum;
    logic [WIDTH_BITS-1:0]  word_new;
    logic [WIDTH_BITS:0]    line_sum;
    logic [WIDTH_BITS-1:0]  line_new;
    logic                   overflow;
    logic                   can_break;

    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    assign m_valid        = out_valid_reg;
    assign m_break_offset = out_offset_reg;
    assign m_forced       = out_forced_reg;
    assign m_reached_end  = out_end_reg;

    always_comb begin
        cur_line        = in_first_reg ? '0   : line_width_reg;
        cur_word        = in_first_reg ? '0   : word_width_reg;
        cur_bvalid      = in_first_reg ? 1'b0 : break_valid_reg;
        cur_bpos        = in_first_reg ? '0   : break_pos_reg;
        cur_byte        = in_first_reg ? '0   : byte_pos_reg;
        cur_after_digit = in_first_reg ? 1'b0 : after_digit_reg;
        cur_finished    = in_first_reg ? 1'b0 : finished_reg;

        nbytes   = (in_bytes_reg == '0) ? BYTES_BITS'(1) : in_bytes_reg;
        next_pos = cur_byte + OFFSET_BITS'(nbytes);

        // saturating sums of word plus advance, then line plus word
        word_sum = {1'b0, cur_word} + {1'b0, WIDTH_BITS'(in_adv_reg)};
        word_new = word_sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : word_sum[WIDTH_BITS-1:0];
        line_sum = {1'b0, cur_line} + {1'b0, word_new};
        line_new = line_sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : line_sum[WIDTH_BITS-1:0];
        overflow = CMP_BITS'(line_new) > CMP_BITS'(wrap_limit_reg);

        can_break = break_after(in_code_reg, in_next_reg, cur_after_digit);
    end

    always_comb begin
        line_width_next  = line_width_reg;
        word_width_next  = word_width_reg;
        break_valid_next = break_valid_reg;
        break_pos_next   = break_pos_reg;
        byte_pos_next    = byte_pos_reg;
        after_digit_next = after_digit_reg;
        finished_next    = finished_reg;
        emit             = 1'b0;
        out_offset_next  = out_offset_reg;
        out_forced_next  = out_forced_reg;
        out_end_next     = out_end_reg;

        if (fire) begin
            line_width_next  = cur_line;
            word_width_next  = cur_word;
            break_valid_next = cur_bvalid;
            break_pos_next   = cur_bpos;
            byte_pos_next    = cur_byte;
            after_digit_next = cur_after_digit;
            finished_next    = cur_finished;

            if (!cur_finished) begin
                if ((in_code_reg != CH_NL) && (in_code_reg != CH_CR) && overflow) begin
                    // line is full: report last break point or force one
                    word_width_next = word_new;
                    finished_next   = 1'b1;
                    emit            = 1'b1;
                    out_end_next    = 1'b0;
                    if (cur_bvalid) begin
                        out_offset_next = cur_bpos;
                        out_forced_next = 1'b0;
                    end else begin
                        out_offset_next = (cur_byte == '0) ? next_pos : cur_byte;
                        out_forced_next = 1'b1;
                    end
                end else begin
                    if (in_code_reg == CH_NL) begin
                        line_width_next  = '0;
                        word_width_next  = '0;
                        break_valid_next = 1'b1;
                        break_pos_next   = next_pos;
                    end else if (in_code_reg != CH_CR) begin
                        if (can_break) begin
                            line_width_next  = line_new;
                            word_width_next  = '0;
                            break_valid_next = 1'b1;
                            break_pos_next   = next_pos;
                        end else begin
                            word_width_next  = word_new;
                        end
                    end
                    after_digit_next = is_digit(in_code_reg);
                    byte_pos_next    = next_pos;
                    if (in_last_reg) begin
                        finished_next   = 1'b1;
                        emit            = 1'b1;
                        out_offset_next = next_pos;
                        out_forced_next = 1'b0;
                        out_end_next    = 1'b1;
                    end
                end
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_limit_reg  <= LIMIT_RESET;
            in_valid_reg    <= 1'b0;
            line_width_reg  <= '0;
            word_width_reg  <= '0;
            break_valid_reg <= 1'b0;
            break_pos_reg   <= '0;
            byte_pos_reg    <= '0;
            after_digit_reg <= 1'b0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                wrap_limit_reg <= cfg_wrap_limit;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            line_width_reg  <= line_width_next;
            word_width_reg  <= word_width_next;
            break_valid_reg <= break_valid_next;
            break_pos_reg   <= break_pos_next;
            byte_pos_reg    <= byte_pos_next;
            after_digit_reg <= after_digit_next;
            finished_reg    <= finished_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_first_reg <= s_first_char;
            in_code_reg  <= s_code_point;
            in_bytes_reg <= s_char_bytes;
            in_adv_reg   <= s_glyph_advance;
            in_next_reg  <= s_next_code;
            in_last_reg  <= s_last_char;
        end
        out_offset_reg <= out_offset_next;
        out_forced_reg <= out_forced_next;
        out_end_reg    <= out_end_next;
    end

    a_forced_not_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_forced && m_reached_end))
        else $error("result flags both forced and end of text");

    a_emit_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> finished_reg)
        else $error("text not marked finished after its result");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_code_reg)))
        else $error("pending request lost while result channel stalled");

    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && finished_reg && !in_first_reg) |-> !emit)
        else $error("result given for a text already finished");

endmodule
